### rtl/lzsswd_pkg.sv
// ============================================================================
// lzsswd_pkg
// Shared types and constants of the LZSS window decompressor.
// ============================================================================
package lzsswd_pkg;

    localparam int unsigned WINDOW_DEPTH = 4096;
    localparam int unsigned WIN_ADDR_W   = $clog2(WINDOW_DEPTH);

    localparam logic [WIN_ADDR_W-1:0] WRITE_START = 12'hfee;
    localparam logic [7:0]            SPACE_CHAR  = 8'h20;
    localparam logic [4:0]            MIN_MATCH   = 5'd3;
    localparam logic [3:0]            FLAG_TOKENS = 4'd8;

    // Window write and read request from the token parser
    typedef struct packed {
        logic                  wr_en;
        logic [WIN_ADDR_W-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic [WIN_ADDR_W-1:0] rd_addr;
    } win_req_t;

endpackage

### rtl/lzss_window_decompressor_unit.sv
// ============================================================================
// lzss_window_decompressor_unit
// LZSS decompressor with a 4096-byte history window.
// ============================================================================
// Usage:
//   s_* carries compressed bytes, s_tlast marks the final byte of a stream.
//   m_* carries decompressed bytes, m_tlast marks the last byte that one
//   input request produced.
//   Flag bytes and first reference bytes produce nothing on m_*.
//   A literal is registered and is on m_* the next cycle.
//   A reference second byte produces length+3 bytes (3..18): the window
//   RAM is read one byte per cycle unless m_tready stalls; each byte goes
//   through the RAM read register and the output register to m_* and is
//   written back as it is emitted. The single read port sets this rate.
//   An output register holds the result; a new request is accepted only in
//   a cycle where that register is empty or its result leaves. A stalled
//   m_tready stops the copy and the input, nothing is lost.
//   After reset and after every stream end the window is refilled by a
//   clearing pass over all 4096 entries, during which s_tready stays low.
// ============================================================================
module lzss_window_decompressor_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // stream_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);
    import lzsswd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COPY = 1'b1;

    logic                  state_reg, state_next;
    logic [WIN_ADDR_W-1:0] wp_reg, wp_next;
    logic [7:0]            flag_bits_reg, flag_bits_next;
    logic [3:0]            flags_rem_reg, flags_rem_next;
    logic                  phase_reg, phase_next;
    logic [7:0]            low_reg, low_next;
    logic [WIN_ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  end_pend_reg, end_pend_next;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_last_reg;

    win_req_t              win_req;
    logic [7:0]            win_rd_data;
    logic                  win_busy;
    logic                  clear_start;

    logic                  s_acc;
    logic                  out_free;
    logic                  emit;
    logic [7:0]            emit_byte;
    logic                  emit_last;
    logic                  restart;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && !win_busy && out_free;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        flag_bits_next = flag_bits_reg;
        flags_rem_next = flags_rem_reg;
        phase_next     = phase_reg;
        low_next       = low_reg;
        rd_addr_next   = rd_addr_reg;
        cnt_next       = cnt_reg;
        end_pend_next  = end_pend_reg;
        emit           = 1'b0;
        emit_byte      = s_tdata;
        emit_last      = 1'b1;
        restart        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (flags_rem_reg == 4'd0) begin
                        flag_bits_next = s_tdata;
                        flags_rem_next = FLAG_TOKENS;
                        phase_next     = 1'b0;
                    end else if (phase_reg) begin
                        rd_addr_next   = {s_tdata[7:4], low_reg};
                        cnt_next       = {1'b0, s_tdata[3:0]} + MIN_MATCH;
                        state_next     = ST_COPY;
                        phase_next     = 1'b0;
                        flag_bits_next = flag_bits_reg >> 1;
                        flags_rem_next = flags_rem_reg - 1'b1;
                    end else if (flag_bits_reg[0]) begin
                        emit           = 1'b1;
                        flag_bits_next = flag_bits_reg >> 1;
                        flags_rem_next = flags_rem_reg - 1'b1;
                    end else begin
                        low_next   = s_tdata;
                        phase_next = 1'b1;
                    end
                    if (s_tlast) begin
                        // a pending copy finishes before the window restarts
                        if (flags_rem_reg != 4'd0 && phase_reg) begin
                            end_pend_next = 1'b1;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                end
            end
            ST_COPY: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_byte    = win_rd_data;
                    emit_last    = (cnt_reg == 5'd1);
                    rd_addr_next = rd_addr_reg + 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    if (cnt_reg == 5'd1) begin
                        state_next = ST_IDLE;
                        if (end_pend_reg) begin
                            restart = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            wp_next = wp_reg + 1'b1;
        end

        if (restart) begin
            wp_next        = WRITE_START;
            flag_bits_next = '0;
            flags_rem_next = '0;
            phase_next     = 1'b0;
            low_next       = '0;
            end_pend_next  = 1'b0;
        end
    end

    always_comb begin
        win_req.wr_en   = emit;
        win_req.wr_addr = wp_reg;
        win_req.wr_data = emit_byte;
        win_req.rd_addr = rd_addr_next;
        clear_start     = restart;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= WRITE_START;
            flag_bits_reg <= '0;
            flags_rem_reg <= '0;
            phase_reg     <= 1'b0;
            low_reg       <= '0;
            rd_addr_reg   <= '0;
            cnt_reg       <= '0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            flag_bits_reg <= flag_bits_next;
            flags_rem_reg <= flags_rem_next;
            phase_reg     <= phase_next;
            low_reg       <= low_next;
            rd_addr_reg   <= rd_addr_next;
            cnt_reg       <= cnt_next;
            end_pend_reg  <= end_pend_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (emit) begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    lzsswd_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (win_req),
        .clear_start (clear_start),
        .rd_data     (win_rd_data),
        .busy        (win_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        win_busy |-> !s_tready)
        else $error("request accepted during clearing pass");
    a_copy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (cnt_reg != 5'd0 && !win_busy))
        else $error("copy active with empty count or busy window");
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (m_tvalid && m_tdata == $past(emit_byte)))
        else $error("emitted byte not presented");
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("output register overwritten");
`endif

endmodule

### rtl/lzsswd_ram.sv
// ============================================================================
// lzsswd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module lzsswd_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a same-address write is seen by the read in the next cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/lzsswd_window.sv
// ============================================================================
// lzsswd_window
// History window: RAM, clearing pass and write-to-read forwarding.
// ============================================================================
module lzsswd_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  lzsswd_pkg::win_req_t req,
    input  logic                clear_start,
    output logic [7:0]          rd_data,
    output logic                busy
);
    import lzsswd_pkg::*;

    logic                  busy_reg, busy_next;
    logic [WIN_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                  fwd_reg;
    logic [7:0]            fwd_data_reg;

    logic                  ram_we;
    logic [WIN_ADDR_W-1:0] ram_waddr;
    logic [7:0]            ram_wdata;
    logic [7:0]            ram_rdata;

    always_comb begin
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_start) begin
            busy_next    = 1'b1;
            clr_cnt_next = '0;
        end else if (busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == WIN_ADDR_W'(WINDOW_DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        if (busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = (clr_cnt_reg < WRITE_START) ? SPACE_CHAR : 8'h00;
        end else begin
            ram_we    = req.wr_en;
            ram_waddr = req.wr_addr;
            ram_wdata = req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
            fwd_reg     <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
            fwd_reg     <= ram_we && (ram_waddr == req.rd_addr);
        end
        fwd_data_reg <= ram_wdata;
    end

    lzsswd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (req.rd_addr),
        .rd_data (ram_rdata)
    );

    // byte written in the same cycle as its read overrides stale RAM data
    assign rd_data = fwd_reg ? fwd_data_reg : ram_rdata;
    assign busy    = busy_reg;

`ifndef SYNTHESIS
    a_clear_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_start |-> !busy_reg)
        else $error("clear requested during clearing pass");
`endif

endmodule

### tb/lzss_window_decompressor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decompressor_unit_tb
// Self-checking bench for the LZSS window decompressor. A scoreboard keeps
// its own copy of the history window and parser state, predicts the
// decompressed bytes for every accepted compressed byte, and compares them in
// order against m_*. Stimulus is directed corner streams first, then random
// well-formed, truncated and noise streams with random idling on both sides.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_unit_tb;
    import lzsswd_pkg::*;

    localparam int STALL_LIMIT  = 20000;  // clearing pass covers all 4096 entries
    localparam int TOTAL_BYTES  = 170;
    localparam int HOLD_CYCLES  = 4600;   // outlasts a clearing pass

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    class lzss_scoreboard;
        logic [7:0]            window [WINDOW_DEPTH];
        logic [WIN_ADDR_W-1:0] wpos;
        logic [7:0]            flags;
        logic [3:0]            tokens_left;
        bit                    ref_pending;
        logic [7:0]            off_low;
        out_byte_t             expected_q[$];
        int                    errors;
        int                    checked;
        int                    literals;
        int                    refs;
        int                    streams;

        function new();
            errors   = 0;
            checked  = 0;
            literals = 0;
            refs     = 0;
            streams  = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window[i] = (i < int'(WRITE_START)) ? SPACE_CHAR : 8'h00;
            end
            wpos        = WRITE_START;
            flags       = '0;
            tokens_left = '0;
            ref_pending = 1'b0;
            off_low     = '0;
        endfunction

        function void put_byte(logic [7:0] b, logic last);
            out_byte_t item;
            window[wpos] = b;
            wpos         = wpos + 1'b1;
            item.data    = b;
            item.last    = last;
            expected_q.push_back(item);
        endfunction

        function void next_token();
            flags = flags >> 1;
            if (tokens_left != 0) tokens_left = tokens_left - 1'b1;
        endfunction

        function void note_input(logic [7:0] b, logic stream_end);
            logic [WIN_ADDR_W-1:0] src;
            int                    len;
            if (tokens_left == 0) begin
                flags       = b;
                tokens_left = FLAG_TOKENS;
                ref_pending = 1'b0;
            end else if (ref_pending) begin
                src = {b[7:4], off_low};
                len = int'(b[3:0]) + int'(MIN_MATCH);
                // overlapping copies read bytes written earlier in this loop
                for (int i = 0; i < len; i++) begin
                    put_byte(window[src + i[WIN_ADDR_W-1:0]], i == len - 1);
                end
                refs++;
                ref_pending = 1'b0;
                next_token();
            end else if (flags[0]) begin
                put_byte(b, 1'b1);
                literals++;
                next_token();
            end else begin
                off_low     = b;
                ref_pending = 1'b1;
            end
            if (stream_end) begin
                streams++;
                restart();
            end
        endfunction

        function void check_result(logic [7:0] data, logic last);
            out_byte_t exp_item;
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_byte %02h run_last %0b", data, last);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            checked++;
            if (data !== exp_item.data) begin
                $error("out_byte: expected %02h, got %02h", exp_item.data, data);
                errors++;
            end
            if (last !== exp_item.last) begin
                $error("run_last: expected %0b, got %0b", exp_item.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // stream_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // run_last

    lzss_scoreboard sb = new();
    int idle_pct   = 9;
    int hold_left  = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    lzss_window_decompressor_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor and watchdog: values read here are the ones seen at the edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on demand
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        for (int i = 0; i < seq.size(); i++) begin
            send_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    // Well-formed stream of flag groups; references point near the write
    // position half the time so that overlapping copies occur
    task automatic send_stream(input int groups, input bit truncate);
        logic [7:0]            seq[$];
        logic [7:0]            flag;
        logic [7:0]            len_byte;
        logic [WIN_ADDR_W-1:0] est_pos;
        logic [WIN_ADDR_W-1:0] off;
        int                    cut;
        est_pos = sb.wpos;
        for (int g = 0; g < groups; g++) begin
            flag = 8'($urandom_range(255));
            seq.push_back(flag);
            for (int t = 0; t < 8; t++) begin
                if (flag[t]) begin
                    seq.push_back(8'($urandom_range(255)));
                    est_pos = est_pos + 1'b1;
                end else begin
                    if ($urandom_range(1)) begin
                        off = est_pos - WIN_ADDR_W'($urandom_range(1, 24));
                    end else begin
                        off = WIN_ADDR_W'($urandom_range(WINDOW_DEPTH - 1));
                    end
                    len_byte = {off[11:8], 4'($urandom_range(15))};
                    seq.push_back(off[7:0]);
                    seq.push_back(len_byte);
                    est_pos = est_pos + len_byte[3:0] + MIN_MATCH;
                end
            end
        end
        if (truncate) begin
            cut = $urandom_range(1, seq.size() - 1);
            repeat (cut) void'(seq.pop_back());
        end
        send_seq(seq);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int r;
        int stream_idx;
        int burst;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // literal extremes, overlapping copy, wrap past the window top, copy
        // of spaces at offset 0, minimum length, and a dangling reference byte
        send_seq('{8'h0b, 8'h00, 8'hff, 8'hee, 8'hf0, 8'h5a, 8'hff, 8'hff,
                   8'h00, 8'h0f, 8'h00, 8'h00, 8'h12});
        send_seq('{8'hff});                 // stream end on a flag byte
        send_seq('{8'h01, 8'ha5});          // stream end on a literal
        send_seq('{8'h00, 8'h34, 8'h12});   // stream end on a reference

        stream_idx = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            if (stream_idx == 1) hold_left = HOLD_CYCLES;
            if (stream_idx == 2) wait_drained();
            // one stretch of the run with no idling on either side
            idle_pct = (bytes_sent >= 60 && bytes_sent < 120) ? 0 : 9;
            r = $urandom_range(99);
            if (r < 75) begin
                send_stream($urandom_range(1, 3), 1'b0);
            end else if (r < 90) begin
                send_stream($urandom_range(1, 2), 1'b1);
            end else begin
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++) begin
                    send_byte(8'($urandom_range(255)),
                              (i == burst - 1) && ($urandom_range(3) == 0));
                end
            end
            stream_idx++;
        end
        idle_pct = 9;

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Run covered %0d compressed bytes, %0d stream ends, %0d literals, %0d refs,",
                 bytes_sent, sb.streams, sb.literals, sb.refs);
        $display("and %0d decompressed bytes compared.", sb.checked);
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
        end
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/lzsswd_pkg.sv
rtl/lzsswd_ram.sv
rtl/lzsswd_window.sv
rtl/lzss_window_decompressor_unit.sv
tb/lzss_window_decompressor_unit_tb.sv
